// File: rtl/sfr_pkg.sv
// shared types, constants and helpers for the serial frame receiver
`default_nettype none

package sfr_pkg;

    localparam int MAX_FRAME = 64;
    localparam int POS_W     = $clog2(MAX_FRAME);
    localparam int LEN_W     = 9;
    localparam int OUT_POS_W = 6;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_DEVID = 2'd1,
        PH_LEN   = 2'd2,
        PH_BODY  = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_SERVO  = 3'd1,
        EV_FAN    = 3'd2,
        EV_RGB    = 3'd3,
        EV_AWAKEN = 3'd4
    } event_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAD_BYTE  = 3'd0,
        CFG_DEVICE_ID  = 3'd1,
        CFG_SERVO_SIGN = 3'd2,
        CFG_FAN_SIGN   = 3'd3,
        CFG_RGB_SIGN   = 3'd4,
        CFG_WAKE_SIGN  = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [BYTE_W-1:0] head_byte;
        logic [BYTE_W-1:0] device_id;
        logic [BYTE_W-1:0] servo_sign;
        logic [BYTE_W-1:0] fan_sign;
        logic [BYTE_W-1:0] rgb_sign;
        logic [BYTE_W-1:0] wake_sign;
    } cfg_t;

    typedef struct packed {
        logic                 in_frame;
        logic [OUT_POS_W-1:0] byte_position;
        logic                 frame_done;
        logic                 checksum_ok;
        event_code_t          event_code;
        logic [BYTE_W-1:0]    event_id;
        logic [OUT_POS_W-1:0] frame_length;
        logic                 oversize_drop;
    } result_t;

    // low output bits of a position or length, for any position width
    function automatic logic [OUT_POS_W-1:0] to_out_pos(input logic [LEN_W-1:0] v);
        return v[OUT_POS_W-1:0];
    endfunction

endpackage : sfr_pkg

`default_nettype wire

// File: rtl/sfr_cfg_regs.sv
// configuration register bank for the frame receiver
`default_nettype none

module sfr_cfg_regs
    import sfr_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  wire logic [BYTE_W-1:0]    cfg_wr_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_wr_index))
                CFG_HEAD_BYTE:  cfg_next.head_byte  = cfg_wr_data;
                CFG_DEVICE_ID:  cfg_next.device_id  = cfg_wr_data;
                CFG_SERVO_SIGN: cfg_next.servo_sign = cfg_wr_data;
                CFG_FAN_SIGN:   cfg_next.fan_sign   = cfg_wr_data;
                CFG_RGB_SIGN:   cfg_next.rgb_sign   = cfg_wr_data;
                CFG_WAKE_SIGN:  cfg_next.wake_sign  = cfg_wr_data;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.head_byte  <= 8'hAA;
            cfg_reg.device_id  <= 8'd1;
            cfg_reg.servo_sign <= 8'd1;
            cfg_reg.fan_sign   <= 8'd2;
            cfg_reg.rgb_sign   <= 8'd3;
            cfg_reg.wake_sign  <= 8'd4;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule : sfr_cfg_regs

`default_nettype wire

// File: rtl/sfr_event_map.sv
// maps an event id byte to an event code, lowest code wins on collision
`default_nettype none

module sfr_event_map
    import sfr_pkg::*;
(
    input  cfg_t                   cfg,
    input  wire logic [BYTE_W-1:0] event_id,
    output event_code_t            event_code
);

    always_comb begin
        priority if (event_id == cfg.servo_sign) begin
            event_code = EV_SERVO;
        end else if (event_id == cfg.fan_sign) begin
            event_code = EV_FAN;
        end else if (event_id == cfg.rgb_sign) begin
            event_code = EV_RGB;
        end else if (event_id == cfg.wake_sign) begin
            event_code = EV_AWAKEN;
        end else begin
            event_code = EV_NONE;
        end
    end

endmodule : sfr_event_map

`default_nettype wire

// File: rtl/sfr_parser.sv
// frame parser: phase machine, position, length, running sum and event id
`default_nettype none

module sfr_parser
    import sfr_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  cfg_t                   cfg,
    input  wire logic              step,
    input  wire logic [BYTE_W-1:0] rx_byte,
    output result_t                res
);

    phase_t             phase_reg,   phase_next;
    logic [POS_W-1:0]   wpos_reg,    wpos_next;
    logic [POS_W-1:0]   exp_len_reg, exp_len_next;
    logic [BYTE_W-1:0]  sum_reg,     sum_next;
    logic [BYTE_W-1:0]  held_id_reg, held_id_next;

    logic [LEN_W-1:0]   len;
    logic               oversize;
    logic               last_byte;
    logic               sum_ok;
    event_code_t        mapped_code;

    assign len       = LEN_W'(rx_byte) + LEN_W'(2);
    assign oversize  = (len >= LEN_W'(MAX_FRAME));
    assign last_byte = ((LEN_W'(wpos_reg) + LEN_W'(1)) >= LEN_W'(exp_len_reg));
    // short frames (length byte below 2) never pass
    assign sum_ok    = (exp_len_reg >= POS_W'(4)) && (rx_byte == sum_reg);

    sfr_event_map u_event_map (
        .cfg        (cfg),
        .event_id   (held_id_next),
        .event_code (mapped_code)
    );

    // next phase
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HUNT:  if (rx_byte == cfg.head_byte) phase_next = PH_DEVID;
            PH_DEVID: phase_next = (rx_byte == cfg.device_id) ? PH_LEN : PH_HUNT;
            PH_LEN:   phase_next = oversize ? PH_HUNT : PH_BODY;
            PH_BODY:  if (last_byte) phase_next = PH_HUNT;
            default:  phase_next = PH_HUNT;
        endcase
    end

    // result and datapath next values
    always_comb begin
        res          = '0;
        wpos_next    = wpos_reg;
        exp_len_next = exp_len_reg;
        sum_next     = sum_reg;
        held_id_next = held_id_reg;
        unique case (phase_reg)
            PH_HUNT: begin
                if (rx_byte == cfg.head_byte) begin
                    res.in_frame = 1'b1;
                    held_id_next = '0;
                end
            end
            PH_DEVID: begin
                if (rx_byte == cfg.device_id) begin
                    res.in_frame      = 1'b1;
                    res.byte_position = OUT_POS_W'(1);
                end
            end
            PH_LEN: begin
                res.byte_position = OUT_POS_W'(2);
                if (oversize) begin
                    res.oversize_drop = 1'b1;
                    wpos_next         = '0;
                    exp_len_next      = '0;
                end else begin
                    res.in_frame     = 1'b1;
                    res.frame_length = to_out_pos(len);
                    exp_len_next     = len[POS_W-1:0];
                    sum_next         = rx_byte;
                    wpos_next        = POS_W'(3);
                end
            end
            PH_BODY: begin
                res.in_frame      = 1'b1;
                res.byte_position = to_out_pos(LEN_W'(wpos_reg));
                res.frame_length  = to_out_pos(LEN_W'(exp_len_reg));
                if (wpos_reg == POS_W'(3)) begin
                    held_id_next = rx_byte;
                end
                if (last_byte) begin
                    res.frame_done  = 1'b1;
                    res.checksum_ok = sum_ok;
                    res.event_code  = sum_ok ? mapped_code : EV_NONE;
                    wpos_next       = '0;
                end else begin
                    sum_next  = (sum_reg + rx_byte) & BYTE_MASK;
                    wpos_next = wpos_reg + POS_W'(1);
                end
            end
            default: ;
        endcase
        res.event_id = held_id_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            wpos_reg    <= '0;
            exp_len_reg <= '0;
            sum_reg     <= '0;
            held_id_reg <= '0;
        end else if (step) begin
            phase_reg   <= phase_next;
            wpos_reg    <= wpos_next;
            exp_len_reg <= exp_len_next;
            sum_reg     <= sum_next;
            held_id_reg <= held_id_next;
        end
    end

endmodule : sfr_parser

`default_nettype wire

// File: rtl/serial_frame_receiver_with_checksum.sv
// top level of the serial frame receiver with header, length and sum check
// a byte's result is registered and shows on m_* in the cycle after its transfer on s_*
// throughput: one byte per cycle while m_ready is high, set by the single output register
// s_ready stays high while the output register is empty or being drained
// reset (aresetn low, synchronous): hunting for a head, no result pending,
// configuration registers back to their default values
`default_nettype none

module serial_frame_receiver_with_checksum
    import sfr_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    // configuration write port
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  wire logic [BYTE_W-1:0]    cfg_wr_data,

    // received byte stream
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [BYTE_W-1:0]    s_rx_byte,

    // per-byte result stream
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_in_frame,
    output logic [OUT_POS_W-1:0]      m_byte_position,
    output logic                      m_frame_done,
    output logic                      m_checksum_ok,
    output logic [2:0]                m_event_code,
    output logic [BYTE_W-1:0]         m_event_id,
    output logic [OUT_POS_W-1:0]      m_frame_length,
    output logic                      m_oversize_drop
);

    cfg_t    cfg;
    result_t res;
    result_t out_reg;
    logic    m_valid_reg, m_valid_next;
    logic    s_xfer;

    // configuration bank; the user must write it only while no byte is in flight, the block does not enforce it
    sfr_cfg_regs u_cfg_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    // input side can move whenever the output register frees up this cycle
    assign s_ready = !m_valid_reg || m_ready;
    assign s_xfer  = s_valid && s_ready;

    // parser state advances only on an input transfer
    sfr_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step    (s_xfer),
        .rx_byte (s_rx_byte),
        .res     (res)
    );

    // output register valid: set by a new transfer, cleared when drained
    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_xfer) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // payload needs no reset, loaded on every input transfer
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            out_reg <= res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_in_frame      = out_reg.in_frame;
    assign m_byte_position = out_reg.byte_position;
    assign m_frame_done    = out_reg.frame_done;
    assign m_checksum_ok   = out_reg.checksum_ok;
    assign m_event_code    = out_reg.event_code;
    assign m_event_id      = out_reg.event_id;
    assign m_frame_length  = out_reg.frame_length;
    assign m_oversize_drop = out_reg.oversize_drop;

    // an input transfer always leaves a result behind
    a_xfer_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> m_valid)
        else $error("input transfer did not produce a result");

    // a completed frame is always part of a frame
    a_done_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_done) |-> m_in_frame)
        else $error("frame_done outside a frame");

    // a dropped oversize frame is never reported as taken
    a_drop_not_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_oversize_drop) |-> (!m_in_frame && m_frame_length == '0))
        else $error("oversize drop reported as frame byte");

    // checksum and event code only appear at frame end, event code only if good
    a_code_needs_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_code != EV_NONE) |-> (m_checksum_ok && m_frame_done))
        else $error("event code without a good checksum at frame end");

    a_ok_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_checksum_ok) |-> m_frame_done)
        else $error("checksum_ok before frame end");

endmodule : serial_frame_receiver_with_checksum

`default_nettype wire
